// File: design/pss_pkg.sv
package pss_pkg;

  // panel geometry, panel size must be a power of two
  localparam int PANEL_SIZE  = 16;
  localparam int PANEL_COUNT = 6;
  localparam int PANEL_LOG2  = $clog2(PANEL_SIZE);

  // link register layout
  localparam int LINK_W    = 5;
  localparam int LINK_REG_W = 4 * LINK_W;
  localparam int CFG_IDX_W = 3;

  // panel index width, at least one bit
  localparam int PANEL_IDX_W = (PANEL_COUNT > 1) ? $clog2(PANEL_COUNT) : 1;

  // heading and side codes share one encoding
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef struct packed {
    logic [6:0] pos_x;
    logic [3:0] pos_y;
    logic [1:0] heading;
  } in_word_t;

  typedef struct packed {
    logic [6:0] next_x;
    logic [3:0] next_y;
    logic [1:0] next_heading;
    logic       crossed;
  } out_word_t;

endpackage

// File: design/panel_surface_step.sv
// panel_surface_step: one step of a pixel walking over a row of square panels
//
// input channel: in_valid_i / in_stall_o carry one word (column, row, heading)
// output channel: out_valid_o / out_stall_i carry one word (new column, new
//   row, new heading, crossed flag); a word moves when valid is high and stall
//   is low
// config: cfg_we_i writes cfg_data_i into link register cfg_index_i at the
//   clock edge; indexes past the last panel are ignored; write only when idle
// latency: 3 cycles, the result sits in the output register two edges after
//   the edge that takes the word and can leave at the edge after that
// throughput: one word per cycle, set by the three register stages
//   (edge detect, link lookup, edge placement) each taking a new word when
//   the stage after it moves on
// stall: a stalled output holds its word; the stages behind fill up and
//   in_stall_o rises only when all three stages hold a word
// reset: rst_ni clears all stage valid bits and all link registers to zero
module panel_surface_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pss_pkg::in_word_t                    in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pss_pkg::out_word_t                   out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [pss_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pss_pkg::LINK_REG_W-1:0]       cfg_data_i
);
  import pss_pkg::*;

  localparam int OFF_W = PANEL_LOG2;
  localparam int COL_W = 3 + PANEL_LOG2 + 1;
  localparam logic [3:0] Y_MASK = 4'(PANEL_SIZE - 1);

  // stage 1: edge detection and plain step
  typedef struct packed {
    logic [1:0]             hd;
    logic                   leaving;
    logic [PANEL_IDX_W-1:0] cur;
    logic [OFF_W-1:0]       e;
    logic [6:0]             plain_x;
    logic [3:0]             plain_y;
  } s1_t;

  // stage 2: looked-up link
  typedef struct packed {
    logic [1:0]       hd;
    logic             leaving;
    logic [2:0]       nb;
    logic [1:0]       ent;
    logic [OFF_W-1:0] e;
    logic [6:0]       plain_x;
    logic [3:0]       plain_y;
  } s2_t;

  logic [LINK_REG_W-1:0] links_q [PANEL_COUNT];

  logic      v1_q, v2_q, v3_q;
  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  out_word_t s3_d, s3_q;
  logic      rdy1, rdy2, rdy3;

  // a stage takes a word when it is empty or its word moves on
  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3_q;
  assign out_word_o  = s3_q;

  // link registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PANEL_COUNT; i++) begin
        links_q[i] <= '0;
      end
    end else if (cfg_we_i && ({1'b0, cfg_index_i} < (CFG_IDX_W + 1)'(PANEL_COUNT))) begin
      links_q[cfg_index_i[PANEL_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // stage 1 logic: local offsets, leaving test, current panel
  logic [OFF_W-1:0] lx, ly;
  logic [6:0]       col_panel;
  always_comb begin
    lx        = in_word_i.pos_x[OFF_W-1:0];
    ly        = OFF_W'(in_word_i.pos_y & Y_MASK);
    col_panel = in_word_i.pos_x >> PANEL_LOG2;

    s1_d.hd      = in_word_i.heading;
    s1_d.plain_x = in_word_i.pos_x;
    s1_d.plain_y = in_word_i.pos_y;
    s1_d.cur     = (col_panel > 7'(PANEL_COUNT - 1)) ? PANEL_IDX_W'(PANEL_COUNT - 1)
                                                     : col_panel[PANEL_IDX_W-1:0];
    case (in_word_i.heading)
      DIR_UP: begin
        s1_d.leaving = (ly == '0);
        s1_d.plain_y = in_word_i.pos_y - 4'd1;
      end
      DIR_RIGHT: begin
        s1_d.leaving = (lx == OFF_W'(PANEL_SIZE - 1));
        s1_d.plain_x = in_word_i.pos_x + 7'd1;
      end
      DIR_DOWN: begin
        s1_d.leaving = (ly == OFF_W'(PANEL_SIZE - 1));
        s1_d.plain_y = in_word_i.pos_y + 4'd1;
      end
      default: begin
        s1_d.leaving = (lx == '0);
        s1_d.plain_x = in_word_i.pos_x - 7'd1;
      end
    endcase
    // offset along the edge being left
    s1_d.e = (in_word_i.heading == DIR_UP || in_word_i.heading == DIR_DOWN) ? lx : ly;
  end

  // stage 2 logic: link lookup and neighbor saturation
  logic [LINK_W-1:0] lnk;
  always_comb begin
    lnk          = links_q[s1_q.cur][LINK_W * s1_q.hd +: LINK_W];
    s2_d.hd      = s1_q.hd;
    s2_d.leaving = s1_q.leaving;
    s2_d.nb      = (lnk[2:0] > 3'(PANEL_COUNT - 1)) ? 3'(PANEL_COUNT - 1) : lnk[2:0];
    s2_d.ent     = lnk[4:3];
    s2_d.e       = s1_q.e;
    s2_d.plain_x = s1_q.plain_x;
    s2_d.plain_y = s1_q.plain_y;
  end

  // stage 3 logic: place the position on the entered edge
  logic [COL_W-1:0] left_col, right_col, e_ext, bot_row;
  logic             invert;
  always_comb begin
    left_col  = COL_W'(s2_q.nb) << PANEL_LOG2;
    right_col = left_col + COL_W'(PANEL_SIZE - 1);
    bot_row   = COL_W'(PANEL_SIZE - 1);
    e_ext     = COL_W'(s2_q.e);
    invert    = (s2_q.hd == DIR_UP) || (s2_q.hd == DIR_RIGHT);

    s3_d.next_x       = s2_q.plain_x;
    s3_d.next_y       = s2_q.plain_y;
    s3_d.next_heading = s2_q.hd;
    s3_d.crossed      = 1'b0;
    if (s2_q.leaving) begin
      s3_d.crossed      = 1'b1;
      s3_d.next_heading = s2_q.ent + 2'd2;
      case (s2_q.ent)
        DIR_UP: begin
          s3_d.next_y = 4'd0;
          s3_d.next_x = 7'(invert ? right_col - e_ext : left_col + e_ext);
        end
        DIR_RIGHT: begin
          s3_d.next_x = 7'(right_col);
          s3_d.next_y = 4'(invert ? bot_row - e_ext : e_ext);
        end
        DIR_DOWN: begin
          s3_d.next_y = 4'(bot_row);
          s3_d.next_x = 7'(invert ? left_col + e_ext : right_col - e_ext);
        end
        default: begin
          s3_d.next_x = 7'(left_col);
          s3_d.next_y = 4'(invert ? e_ext : bot_row - e_ext);
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage data, no reset needed
  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
  end

  // input stalls only with a full pipe and a stalled output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i))
    else $error("input stalled with room in the pipe");

  // a blocked stage 1 word stays put
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(s1_q)))
    else $error("stage 1 word lost while blocked");

  // a blocked stage 2 word stays put
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> (v2_q && $stable(s2_q)))
    else $error("stage 2 word lost while blocked");

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  // idle cycles tolerated on both channels before the run is called hung
  localparam int WATCHDOG_CYCLES = 2000;
  // cycles to let the pipeline settle after the last result
  localparam int DRAIN_CYCLES    = 8;
  // random steps per link setting
  localparam int STEPS_PER_SETTING = 160;
  localparam int RANDOM_SETTINGS   = 9;

  // clock, reset and every block input start at known values
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [LINK_REG_W-1:0] cfg_data_i  = '0;

  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  panel_surface_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // link registers as the block should hold them, plus the set about to be written
  logic [LINK_REG_W-1:0] link_shadow  [PANEL_COUNT];
  logic [LINK_REG_W-1:0] staged_links [PANEL_COUNT];

  in_word_t  pending_steps [$];   // words waiting for the driver
  out_word_t expected_steps [$];  // predicted results, oldest first

  int  items_queued   = 0;
  int  steps_taken    = 0;
  int  steps_checked  = 0;
  int  crossings_seen = 0;
  int  settings_used  = 0;
  int  fail_count     = 0;
  int  in_pause       = 0;
  int  stall_left     = 0;
  bit  in_taken       = 1'b0;
  bit  in_idle_on     = 1'b1;
  bit  out_idle_on    = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // one step on the panel surface, worked out from the shadow link registers
  function automatic out_word_t step_prediction(in_word_t w);
    out_word_t res;
    int x, y, lx, ly, nx, ny, cur, nb, e, left_col, right_col, bot_row;
    logic [1:0] hd, ent, nh;
    logic [LINK_W-1:0] lnk;
    bit leaving, invert;
    x  = int'(w.pos_x);
    y  = int'(w.pos_y);
    hd = w.heading;
    lx = x % PANEL_SIZE;
    ly = y % PANEL_SIZE;
    nx = x;
    ny = y;
    nh = hd;
    case (hd)
      DIR_UP:    leaving = (ly == 0);
      DIR_RIGHT: leaving = (lx == PANEL_SIZE - 1);
      DIR_DOWN:  leaving = (ly == PANEL_SIZE - 1);
      default:   leaving = (lx == 0);
    endcase
    res.crossed = leaving;
    if (!leaving) begin
      // plain step inside the panel
      case (hd)
        DIR_UP:    ny = y - 1;
        DIR_RIGHT: nx = x + 1;
        DIR_DOWN:  ny = y + 1;
        default:   nx = x - 1;
      endcase
    end else begin
      // columns past the last panel use the last panel's links
      cur = x / PANEL_SIZE;
      if (cur > PANEL_COUNT - 1) cur = PANEL_COUNT - 1;
      lnk = link_shadow[cur][LINK_W*hd +: LINK_W];
      nb  = int'(lnk[2:0]);
      if (nb > PANEL_COUNT - 1) nb = PANEL_COUNT - 1;
      ent = lnk[4:3];
      left_col  = nb * PANEL_SIZE;
      right_col = left_col + PANEL_SIZE - 1;
      bot_row   = PANEL_SIZE - 1;
      e = (hd == DIR_UP || hd == DIR_DOWN) ? lx : ly;
      // leaving top or right mirrors the offset on the far edge
      invert = (hd == DIR_UP || hd == DIR_RIGHT);
      case (ent)
        DIR_UP: begin
          nh = DIR_DOWN;
          ny = 0;
          nx = invert ? right_col - e : left_col + e;
        end
        DIR_RIGHT: begin
          nh = DIR_LEFT;
          nx = right_col;
          ny = invert ? bot_row - e : e;
        end
        DIR_DOWN: begin
          nh = DIR_UP;
          ny = bot_row;
          nx = invert ? left_col + e : right_col - e;
        end
        default: begin
          nh = DIR_RIGHT;
          nx = left_col;
          ny = invert ? e : bot_row - e;
        end
      endcase
    end
    res.next_x       = nx[6:0];
    res.next_y       = ny[3:0];
    res.next_heading = nh;
    return res;
  endfunction

  // a position on the leaving edge of a panel for the given heading
  function automatic in_word_t leaving_spot(int panel, logic [1:0] hd, int offset);
    in_word_t w;
    int col, row;
    case (hd)
      DIR_UP: begin
        col = panel * PANEL_SIZE + offset;
        row = 0;
      end
      DIR_RIGHT: begin
        col = panel * PANEL_SIZE + PANEL_SIZE - 1;
        row = offset;
      end
      DIR_DOWN: begin
        col = panel * PANEL_SIZE + offset;
        row = PANEL_SIZE - 1;
      end
      default: begin
        col = panel * PANEL_SIZE;
        row = offset;
      end
    endcase
    w.pos_x   = col[6:0];
    w.pos_y   = row[3:0];
    w.heading = hd;
    return w;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int draw_pause(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic queue_step(in_word_t w);
    pending_steps.push_back(w);
    items_queued++;
  endtask

  // write all link registers, then the unused indexes, which must be ignored
  task automatic program_links();
    for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[CFG_IDX_W-1:0];
      if (idx < PANEL_COUNT) cfg_data_i <= staged_links[idx];
      else cfg_data_i <= LINK_REG_W'($urandom);
      @(posedge clk_i);
      if (idx < PANEL_COUNT) link_shadow[idx] = staged_links[idx];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // wait until every queued word went in and its result came back
  task automatic wait_drained();
    while (steps_taken < items_queued || expected_steps.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // input driver: holds a stalled word, otherwise inserts a gap or the next word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_pause > 0) begin
          in_valid_i <= 1'b0;
          in_pause--;
        end else if (pending_steps.size() != 0) begin
          in_word_i  <= pending_steps.pop_front();
          in_valid_i <= 1'b1;
          in_pause   = draw_pause(in_idle_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side back-pressure in runs of random length
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  = draw_pause(out_idle_on);
      end
    end
  end

  // monitor: predicts on every accepted input word, checks every accepted result
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      // the prediction goes in first so a same-edge result still finds it
      if (in_valid_i && !in_stall_o) begin
        expected_steps.push_back(step_prediction(in_word_i));
        steps_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          $error("result word with nothing expected: %p", out_word_o);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          steps_checked++;
          if (want.crossed) crossings_seen++;
          if (out_word_o.next_x !== want.next_x) begin
            $error("next_x: expected %0d, actual %0d", want.next_x, out_word_o.next_x);
            fail_count++;
          end
          if (out_word_o.next_y !== want.next_y) begin
            $error("next_y: expected %0d, actual %0d", want.next_y, out_word_o.next_y);
            fail_count++;
          end
          if (out_word_o.next_heading !== want.next_heading) begin
            $error("next_heading: expected %0d, actual %0d",
                   want.next_heading, out_word_o.next_heading);
            fail_count++;
          end
          if (out_word_o.crossed !== want.crossed) begin
            $error("crossed: expected %0d, actual %0d", want.crossed, out_word_o.crossed);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: no word moving on either channel for too long ends the run
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_word_t  w;
    in_word_t  walk_pos;
    out_word_t walk_next;
    int nb, ent, panel, offset;
    logic [LINK_W-1:0] field;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed setting: every panel side reaches a different entered side,
    // neighbor codes include the two past the last panel
    for (int p = 0; p < PANEL_COUNT; p++) begin
      for (int k = 0; k < 4; k++) begin
        nb  = (p + k + 4) % 8;
        ent = (p + k) % 4;
        field = {ent[1:0], nb[2:0]};
        staged_links[p][LINK_W*k +: LINK_W] = field;
      end
    end
    program_links();
    @(posedge clk_i);

    // leaving edges for each heading, offsets at both ends, one panel past
    // the last panel, then plain steps and the all-ones corner
    for (int h = 0; h < 4; h++) begin
      for (int j = 0; j < 5; j++) begin
        panel  = (j == 4) ? 6 : j;
        offset = (j % 2 == 1) ? PANEL_SIZE - 1 : j * 3;
        queue_step(leaving_spot(panel, h[1:0], offset));
      end
    end
    for (int h = 0; h < 4; h++) begin
      w.pos_x   = 7'd40;
      w.pos_y   = 4'd7;
      w.heading = h[1:0];
      queue_step(w);
    end
    w.pos_x   = 7'd127;
    w.pos_y   = 4'd15;
    w.heading = DIR_DOWN;
    queue_step(w);
    wait_drained();

    // random part: first all-ones, then all-zero links, then random link sets
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      for (int p = 0; p < PANEL_COUNT; p++) begin
        if (s == 0) staged_links[p] = '1;
        else if (s == 1) staged_links[p] = '0;
        else staged_links[p] = LINK_REG_W'($urandom);
      end
      program_links();
      // some settings run with no gaps at all on one or both sides
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      @(posedge clk_i);

      walk_pos.pos_x   = 7'($urandom_range(0, PANEL_SIZE * PANEL_COUNT - 1));
      walk_pos.pos_y   = 4'($urandom_range(0, PANEL_SIZE - 1));
      walk_pos.heading = 2'($urandom);
      for (int n = 0; n < STEPS_PER_SETTING; n++) begin
        case ($urandom_range(0, 3))
          0: begin
            // any field value, including columns past the last panel
            w.pos_x   = 7'($urandom);
            w.pos_y   = 4'($urandom);
            w.heading = 2'($urandom);
            queue_step(w);
          end
          1: queue_step(leaving_spot(int'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                     int'($urandom_range(0, PANEL_SIZE - 1))));
          default: begin
            // a walker that follows its own path across the panels
            if ($urandom_range(0, 7) == 0) walk_pos.heading = 2'($urandom);
            queue_step(walk_pos);
            walk_next = step_prediction(walk_pos);
            walk_pos.pos_x   = walk_next.next_x;
            walk_pos.pos_y   = walk_next.next_y;
            walk_pos.heading = walk_next.next_heading;
          end
        endcase
      end
      wait_drained();
    end

    $display("checked %0d steps, %0d of them across panel edges", steps_checked,
             crossings_seen);
    $display("under %0d link register settings, with random gaps and stalls",
             settings_used);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pss_pkg.sv
design/panel_surface_step.sv
verif/tb_top.sv
